### hw/rtl/qsu_pkg.sv
// Package with the shared types and constants of the quoted string unescaper.
package qsu_pkg;

	localparam int COUNT_BITS = 24;
	localparam int LEN_BITS   = 24;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_X = 8'h78;
	localparam logic [7:0] CH_B = 8'h62;
	localparam logic [7:0] CH_F = 8'h66;
	localparam logic [7:0] CH_N = 8'h6E;
	localparam logic [7:0] CH_R = 8'h72;
	localparam logic [7:0] CH_T = 8'h74;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CC_BS = 8'h08;
	localparam logic [7:0] CC_FF = 8'h0C;
	localparam logic [7:0] CC_LF = 8'h0A;
	localparam logic [7:0] CC_CR = 8'h0D;
	localparam logic [7:0] CC_TAB = 8'h09;
	localparam logic [7:0] CC_NUL = 8'h00;

	typedef enum logic [2:0] {
		PH_IDLE = 3'd0,
		PH_STR  = 3'd1,
		PH_ESC  = 3'd2,
		PH_HEX1 = 3'd3,
		PH_HEX2 = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		ST_BYTE = 2'd0,
		ST_DONE = 2'd1,
		ST_ERR  = 2'd2
	} status_t;

	typedef struct packed {
		phase_t                phase;
		logic [3:0]            high_nibble;
		logic [COUNT_BITS-1:0] count;
	} dec_state_t;

	typedef struct packed {
		logic                valid;
		status_t             status;
		logic [7:0]          out_byte;
		logic [LEN_BITS-1:0] string_length;
	} dec_result_t;

endpackage

### hw/rtl/quoted_string_unescape.sv
// Top level of the quoted string unescaper: decode state, output register and skid stage.
//
//   channel  direction  handshake             payload
//   input    in         in_valid / in_ready   kind, data_byte
//   output   out        out_valid / out_ready status, out_byte, string_length
//
// One byte per cycle while in_ready is high: the edge that accepts a transaction also updates the
// decode state and writes its result (if any) into the output register, or into the skid register
// when the output register is full and stalled; a result written to the output register
// shows on the output in the next cycle. The state update does not iterate.
// Reset (arst_n low) returns to waiting for an opening quote with a zero count.
// A stalled output parks one result in a skid register; in_ready drops only while
// the skid register is occupied, so a held result does not stop the next byte.
module quoted_string_unescape import qsu_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                kind,
	input  logic [7:0]          data_byte,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [1:0]          status,
	output logic [7:0]          out_byte,
	output logic [LEN_BITS-1:0] string_length
);

	dec_state_t  state_q;
	dec_state_t  state_nxt;
	dec_result_t res;
	dec_result_t out_q;
	dec_result_t skid_q;
	logic        accept;
	logic        out_free;

	qsu_decode u_decode (
		.cur       (state_q),
		.kind      (kind),
		.data_byte (data_byte),
		.nxt       (state_nxt),
		.res       (res)
	);

	// The skid register is the only thing that can block the input side.
	assign in_ready = !skid_q.valid;
	assign accept   = in_valid && in_ready;
	// The output register can take a new result when it is empty or being drained.
	assign out_free = !out_q.valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase       <= PH_IDLE;
			state_q.high_nibble <= 4'd0;
			state_q.count       <= '0;
		end else if (accept) begin
			state_q <= state_nxt;
		end
	end

	// Output register plus skid. While the skid is full no transaction is accepted,
	// so the only move then is skid into the output register once it drains.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_q.valid  <= 1'b0;
			skid_q.valid <= 1'b0;
		end else begin
			if (skid_q.valid) begin
				if (out_ready) begin
					out_q        <= skid_q;
					skid_q.valid <= 1'b0;
				end
			end else if (accept && res.valid) begin
				if (out_free) begin
					out_q <= res;
				end else begin
					skid_q <= res;
				end
			end else if (out_ready) begin
				out_q.valid <= 1'b0;
			end
		end
	end

	assign out_valid     = out_q.valid;
	assign status        = out_q.status;
	assign out_byte      = out_q.out_byte;
	assign string_length = out_q.string_length;

endmodule

### hw/rtl/qsu_decode.sv
// Combinational next-state and result logic for one input byte.
module qsu_decode import qsu_pkg::*; (
	input  dec_state_t  cur,
	input  logic        kind,
	input  logic [7:0]  data_byte,
	output dec_state_t  nxt,
	output dec_result_t res
);

	logic       hex_ok;
	logic [3:0] hex_val;
	logic       emit_en;
	logic [7:0] emit_val;
	logic       fail_en;

	// Hex digit recognition, either case.
	always_comb begin
		hex_ok  = 1'b1;
		hex_val = 4'd0;
		case (data_byte) inside
			[8'h30:8'h39]: hex_val = data_byte[3:0];
			[8'h41:8'h46], [8'h61:8'h66]: hex_val = data_byte[3:0] + 4'd9;
			default: hex_ok = 1'b0;
		endcase
	end

	always_comb begin
		nxt      = cur;
		res      = '0;
		emit_en  = 1'b0;
		emit_val = data_byte;
		fail_en  = 1'b0;
		if (kind) begin
			fail_en = 1'b1;
		end else begin
			case (cur.phase)
				PH_IDLE: begin
					if (data_byte == CH_QUOTE) begin
						nxt.count       = '0;
						nxt.high_nibble = 4'd0;
						nxt.phase       = PH_STR;
					end else begin
						fail_en = 1'b1;
					end
				end
				PH_STR: begin
					if (data_byte == CH_QUOTE) begin
						nxt.phase         = PH_IDLE;
						res.valid         = 1'b1;
						res.status        = ST_DONE;
						res.string_length = LEN_BITS'(cur.count);
					end else if (data_byte == CH_BSLASH) begin
						nxt.phase = PH_ESC;
					end else begin
						emit_en = 1'b1;
					end
				end
				PH_ESC: begin
					emit_en = 1'b1;
					case (data_byte)
						CH_B:    emit_val = CC_BS;
						CH_F:    emit_val = CC_FF;
						CH_N:    emit_val = CC_LF;
						CH_R:    emit_val = CC_CR;
						CH_T:    emit_val = CC_TAB;
						CH_ZERO: emit_val = CC_NUL;
						CH_X: begin
							emit_en   = 1'b0;
							nxt.phase = PH_HEX1;
						end
						default: emit_val = data_byte;
					endcase
				end
				PH_HEX1: begin
					if (hex_ok) begin
						nxt.high_nibble = hex_val;
						nxt.phase       = PH_HEX2;
					end else begin
						fail_en = 1'b1;
					end
				end
				PH_HEX2: begin
					if (hex_ok) begin
						emit_en  = 1'b1;
						emit_val = {cur.high_nibble, hex_val};
					end else begin
						fail_en = 1'b1;
					end
				end
				default: fail_en = 1'b1;
			endcase
		end

		if (emit_en) begin
			nxt.phase    = PH_STR;
			res.valid    = 1'b1;
			res.status   = ST_BYTE;
			res.out_byte = emit_val;
			if (cur.count != COUNT_MAX) begin
				nxt.count = cur.count + 1'b1;
			end
		end
		if (fail_en) begin
			nxt.phase       = PH_IDLE;
			nxt.high_nibble = 4'd0;
			res.valid       = 1'b1;
			res.status      = ST_ERR;
		end
	end

endmodule

### hw/rtl/qsu_checker.sv
// Port-level assertions for the quoted string unescaper, bound to the top level.
module qsu_checker import qsu_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                kind,
	input logic                out_valid,
	input logic                out_ready,
	input logic [1:0]          status,
	input logic [7:0]          out_byte,
	input logic [LEN_BITS-1:0] string_length
);

	// A stalled result holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(out_byte)
			&& $stable(string_length))
		else $error("output result changed while stalled");

	// An end-of-input transaction always yields a result, so output is busy next cycle.
	a_end_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && kind |=> out_valid)
		else $error("end of input produced no result");

	// Only a decoded byte carries a byte value.
	a_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_BYTE |-> out_byte == 8'd0)
		else $error("nonzero byte on a non-byte result");

	// Only a finished string carries a length.
	a_len_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_DONE |-> string_length == '0)
		else $error("nonzero length on a result that is not a finished string");

endmodule

bind quoted_string_unescape qsu_checker u_qsu_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.kind          (kind),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.status        (status),
	.out_byte      (out_byte),
	.string_length (string_length)
);
